// ===== hw/rtl/fvn_pkg.sv =====
`default_nettype none
package fvn_pkg;

  localparam int COORD_BITS    = 16;
  localparam int SCALE_DIVISOR = 20;
  localparam int MAX_OCTAVES   = 16;

  // register and payload widths
  localparam int OCT_W   = 4;
  localparam int NOISE_W = 19;
  localparam int REM_W   = $clog2(SCALE_DIVISOR);
  localparam int LAT_W   = 32;

  // datapath widths
  localparam int W_W    = 17;   // cosine weight, Q16, 0..65536
  localparam int G_W    = 18;   // lattice value, Q16
  localparam int H_W    = 20;   // row-smoothed value
  localparam int V_W    = 22;   // smoothed value, Q20
  localparam int I_W    = 38;   // first blend, Q36
  localparam int O_W    = 54;   // second blend, Q52
  localparam int O_SHIFT = 20;  // Q52 down to Q32
  localparam int O32_W  = O_W - O_SHIFT;
  localparam int ACC_W  = O32_W + MAX_OCTAVES + 1;
  localparam int RND_SHIFT = MAX_OCTAVES - 1 + 16;

  localparam int W_FRAC = 16;
  localparam logic [W_W-1:0] W_ONE = W_W'(65536);

  // reciprocal for the first division of a coordinate by the scale divisor
  localparam int RECIP_SHIFT = COORD_BITS + 7;
  localparam longint RECIP = ((64'd1 << RECIP_SHIFT) + SCALE_DIVISOR - 1) / SCALE_DIVISOR;

  // integer lattice hash constants
  localparam logic [LAT_W-1:0] HASH_ROW = 32'd57;
  localparam logic [LAT_W-1:0] HASH_K1  = 32'd15731;
  localparam logic [LAT_W-1:0] HASH_K2  = 32'd789221;
  localparam logic [LAT_W-1:0] HASH_K3  = 32'd1376312589;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // one octave's worth of state handed from cell to cell
  typedef struct packed {
    logic [LAT_W-1:0]        ix;
    logic [LAT_W-1:0]        iy;
    logic [REM_W-1:0]        rx;
    logic [REM_W-1:0]        ry;
    logic signed [ACC_W-1:0] acc;
  } oct_word_t;

  typedef logic [W_W-1:0] wtab_t [SCALE_DIVISOR];

  // sin^2 of half the angle by a fixed-point series, rounded to Q16
  function automatic logic [W_W-1:0] w_low(longint unsigned r);
    longint unsigned phi;
    longint unsigned p2;
    longint unsigned t;
    longint unsigned su;
    longint unsigned f;
    longint s;
    phi = (PI_Q30 * r) / (2 * SCALE_DIVISOR);
    p2 = (phi * phi) >> 30;
    t = phi;
    s = longint'(t);
    t = ((t * p2) >> 30) / 6;  s = s - longint'(t);
    t = ((t * p2) >> 30) / 20; s = s + longint'(t);
    t = ((t * p2) >> 30) / 42; s = s - longint'(t);
    t = ((t * p2) >> 30) / 72; s = s + longint'(t);
    if (s < 0) s = 0;
    su = longint'(s);
    f = (su * su) >> 30;
    return W_W'((f + 64'd8192) >> 14);
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t tab;
    for (int r = 0; r < SCALE_DIVISOR; r++) begin
      if (2 * r > SCALE_DIVISOR) begin
        tab[r] = W_ONE - w_low(longint'(SCALE_DIVISOR - r));
      end else begin
        tab[r] = w_low(longint'(r));
      end
    end
    return tab;
  endfunction

  localparam wtab_t COS_W = build_wtab();

endpackage
`default_nettype wire

// ===== hw/rtl/fvn_coord_if.sv =====
`default_nettype none
interface fvn_coord_if
  import fvn_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fvn_noise_if.sv =====
`default_nettype none
interface fvn_noise_if
  import fvn_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fvn_cfg_if.sv =====
`default_nettype none
interface fvn_cfg_if
  import fvn_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OCT_W-1:0] top_octave;
  modport source (output valid, output top_octave, input ready);
  modport sink   (input valid, input top_octave, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fractal_value_noise_2d_unit.sv =====
`default_nettype none
// fractal 2-d value noise: one word on coord (x, y) gives one word on noise,
// signed q16 saturated to +-2.0. a row of sixteen octave cells, each a nine
// stage pipeline with sixteen lattice hash pipes, sits between a one-stage
// front (coordinate split by the scale divisor) and the output register, so a
// new coordinate word is taken every cycle unless the pipe waits on the output;
// octaves above top_octave pass through their cell without adding.
// the output register holds a result until it is taken; the pipe keeps
// moving while its last stage is empty, otherwise it waits with the output.
// cfg writes top_octave (reset 8) and is always ready; write it only while
// no coordinate word is in flight.
module fractal_value_noise_2d_unit
  import fvn_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  fvn_coord_if.sink   coord,
  fvn_noise_if.source noise,
  fvn_cfg_if.sink     cfg
);

  localparam int PROD_W = COORD_BITS + RECIP_SHIFT;

  logic [OCT_W-1:0] top_octave;

  // pipe control
  logic advance;
  logic out_free;
  logic feed_valid;

  // front stage
  logic              front_valid;
  oct_word_t         front_word;
  logic [PROD_W-1:0] qx_prod;
  logic [PROD_W-1:0] qy_prod;
  logic [COORD_BITS-1:0] qx;
  logic [COORD_BITS-1:0] qy;

  // cell chain
  logic [MAX_OCTAVES:0] vch;
  oct_word_t            wch [MAX_OCTAVES+1];

  // output rounding
  logic signed [ACC_W-1:0] rounded;
  logic signed [ACC_W-1:0] res;
  logic signed [NOISE_W-1:0] sat;
  logic signed [NOISE_W-1:0] noise_value;
  logic                      out_valid;

  // config register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      top_octave <= OCT_W'(8);
    end else if (cfg.valid) begin
      top_octave <= cfg.top_octave;
    end
  end

  // the pipe stalls only when a result is waiting and another is right behind
  assign feed_valid = vch[MAX_OCTAVES];
  assign out_free   = !out_valid || noise.ready;
  assign advance    = out_free || !feed_valid;
  assign coord.ready = advance;

  // coordinate / divisor by reciprocal multiply, exact over the coordinate range
  assign qx_prod = PROD_W'(coord.x_coord) * PROD_W'(RECIP);
  assign qy_prod = PROD_W'(coord.y_coord) * PROD_W'(RECIP);
  assign qx = COORD_BITS'(qx_prod >> RECIP_SHIFT);
  assign qy = COORD_BITS'(qy_prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (advance) begin
      front_valid <= coord.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      front_word.ix  <= LAT_W'(qx);
      front_word.iy  <= LAT_W'(qy);
      front_word.rx  <= REM_W'(coord.x_coord - qx * COORD_BITS'(SCALE_DIVISOR));
      front_word.ry  <= REM_W'(coord.y_coord - qy * COORD_BITS'(SCALE_DIVISOR));
      front_word.acc <= '0;
    end
  end

  assign vch[0] = front_valid;
  assign wch[0] = front_word;

  // one cell per octave
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fvn_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .octave     (OCT_W'(i)),
      .top_octave (top_octave),
      .in_valid   (vch[i]),
      .in_word    (wch[i]),
      .out_valid  (vch[i+1]),
      .out_word   (wch[i+1])
    );
  end

  // round half up from q47 to q16, then clip to +-2.0
  assign rounded = wch[MAX_OCTAVES].acc + (ACC_W'(1) <<< (RND_SHIFT - 1));
  assign res     = rounded >>> RND_SHIFT;

  always_comb begin
    if (res > $signed(ACC_W'(131072))) begin
      sat = NOISE_W'(131072);
    end else if (res < -$signed(ACC_W'(131072))) begin
      sat = -NOISE_W'(131072);
    end else begin
      sat = NOISE_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (feed_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (noise.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (feed_valid && out_free) begin
      noise_value <= sat;
    end
  end

  assign noise.valid       = out_valid;
  assign noise.noise_value = noise_value;

endmodule
`default_nettype wire

// ===== hw/rtl/fvn_hash.sv =====
`default_nettype none
module fvn_hash
  import fvn_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [LAT_W-1:0]        lx,
  input  wire logic [LAT_W-1:0]        ly,
  output logic signed [G_W-1:0]        g
);

  logic [LAT_W-1:0] mix;
  logic [LAT_W-1:0] n_comb;
  logic [LAT_W-1:0] n_a;
  logic [LAT_W-1:0] n_b;
  logic [LAT_W-1:0] n_c;
  logic [LAT_W-1:0] sq_b;
  logic [LAT_W-1:0] a_c;
  logic [LAT_W-1:0] h_c;

  assign mix    = lx + ly * HASH_ROW;
  assign n_comb = (mix << 13) ^ mix;
  assign h_c    = n_c * a_c + HASH_K3;

  always_ff @(posedge clk) begin
    if (en) begin
      n_a  <= n_comb;
      n_b  <= n_a;
      sq_b <= n_a * n_a;
      n_c  <= n_b;
      a_c  <= sq_b * HASH_K1 + HASH_K2;
      // 65536 minus the top 17 bits of the masked hash
      g    <= G_W'(65536) - $signed({1'b0, h_c[30:14]});
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fvn_cell.sv =====
`default_nettype none
module fvn_cell
  import fvn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [OCT_W-1:0] octave,
  input  wire logic [OCT_W-1:0] top_octave,
  input  wire logic             in_valid,
  input  wire oct_word_t        in_word,
  output logic                  out_valid,
  output oct_word_t             out_word
);

  localparam int SIDE_N = 8;

  typedef struct packed {
    oct_word_t        nxt;
    logic [W_W-1:0]   wx;
    logic [W_W-1:0]   wy;
    logic             act;
  } side_t;

  side_t side_in;
  side_t sd [SIDE_N];
  logic [SIDE_N:0] vld;

  logic              cx;
  logic              cy;
  logic [LAT_W-1:0]  gx [4];
  logic [LAT_W-1:0]  gy [4];
  logic signed [G_W-1:0] g [4][4];

  logic signed [H_W-1:0] h [4][2];
  logic signed [V_W-1:0] v [2][2];
  logic signed [I_W-1:0] blx [2];
  logic signed [O_W-1:0] o;
  logic [OCT_W-1:0]      shamt;
  logic signed [ACC_W-1:0] term;
  oct_word_t             out_next;

  // next octave: double the position, carry out of the remainder
  assign cx = ({1'b0, in_word.rx, 1'b0} >= (REM_W + 2)'(SCALE_DIVISOR));
  assign cy = ({1'b0, in_word.ry, 1'b0} >= (REM_W + 2)'(SCALE_DIVISOR));

  always_comb begin
    side_in.nxt.ix  = {in_word.ix[LAT_W-2:0], 1'b0} + LAT_W'(cx);
    side_in.nxt.iy  = {in_word.iy[LAT_W-2:0], 1'b0} + LAT_W'(cy);
    side_in.nxt.rx  = REM_W'({in_word.rx, 1'b0} - (cx ? (REM_W + 1)'(SCALE_DIVISOR) : '0));
    side_in.nxt.ry  = REM_W'({in_word.ry, 1'b0} - (cy ? (REM_W + 1)'(SCALE_DIVISOR) : '0));
    side_in.nxt.acc = in_word.acc;
    side_in.wx      = COS_W[in_word.rx];
    side_in.wy      = COS_W[in_word.ry];
    side_in.act     = (octave <= top_octave);
  end

  // 4x4 lattice neighbourhood, one hash pipe per point
  for (genvar k = 0; k < 4; k++) begin : g_coord
    assign gx[k] = in_word.ix + LAT_W'(k) - LAT_W'(1);
    assign gy[k] = in_word.iy + LAT_W'(k) - LAT_W'(1);
  end

  for (genvar j = 0; j < 4; j++) begin : g_row
    for (genvar k = 0; k < 4; k++) begin : g_col
      fvn_hash u_hash (
        .clk (clk),
        .en  (en),
        .lx  (gx[k]),
        .ly  (gy[j]),
        .g   (g[j][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SIDE_N-1:0], in_valid};
    end
  end

  assign shamt = OCT_W'(MAX_OCTAVES - 1) - octave;
  assign term  = ACC_W'(o >>> O_SHIFT) <<< shamt;

  // add this octave's term only when it is in use
  always_comb begin
    out_next = sd[7].nxt;
    if (sd[7].act) begin
      out_next.acc = sd[7].nxt.acc + term;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      for (int s = 1; s < SIDE_N; s++) begin
        sd[s] <= sd[s-1];
      end
      // horizontal 1-2-1 pass
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 2; k++) begin
          h[j][k] <= H_W'(g[j][k]) + (H_W'(g[j][k+1]) <<< 1) + H_W'(g[j][k+2]);
        end
      end
      // vertical 1-2-1 pass
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          v[j][k] <= V_W'(h[j][k]) + (V_W'(h[j+1][k]) <<< 1) + V_W'(h[j+2][k]);
        end
      end
      // blend along x
      for (int j = 0; j < 2; j++) begin
        blx[j] <= (I_W'(v[j][0]) <<< W_FRAC)
                + (I_W'(v[j][1]) - I_W'(v[j][0])) * I_W'($signed({1'b0, sd[5].wx}));
      end
      // blend along y
      o <= (O_W'(blx[0]) <<< W_FRAC)
         + (O_W'(blx[1]) - O_W'(blx[0])) * O_W'($signed({1'b0, sd[6].wy}));
      out_word <= out_next;
    end
  end

  assign out_valid = vld[SIDE_N];

endmodule
`default_nettype wire

// ===== hw/rtl/fvn_checker.sv =====
`default_nettype none
module fvn_checker
  import fvn_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [NOISE_W-1:0] noise_value,
  input wire logic                      cfg_ready
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before taken");

  // a waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(noise_value))
    else $error("result word changed while stalled");

  // saturation bound
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (noise_value <= $signed(NOISE_W'(131072))
                   && noise_value >= -$signed(NOISE_W'(131072))))
    else $error("noise word outside +-2.0");

  // no result right after reset: the pipe is empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind fractal_value_noise_2d_unit fvn_checker u_fvn_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (noise.valid),
  .out_ready   (noise.ready),
  .noise_value (noise.noise_value),
  .cfg_ready   (cfg.ready)
);
`default_nettype wire
